>>> rtl/rtlpm_pkg.sv
// rtlpm_pkg: shared types, codes and helpers for the route trie LPM core.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none
package rtlpm_pkg;

  localparam int ADDR_BITS = 32;
  localparam int TOP_BIT   = 31;
  localparam int DEPTH_W   = 6;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = 6'd32;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture a new beat, start at the root
    logic descend;  // follow an existing child link
    logic alloc;    // link a fresh node and move onto it
    logic mark;     // mark the current node with the route
    logic track;    // remember the current node if marked
    logic finish;   // latch the result
    logic fail;     // insert ran out of nodes
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic at_end;
    logic link_null;
    logic store_full;
  } dp_stat_t;

  function automatic logic [ADDR_BITS-1:0] swap_bytes(input logic [ADDR_BITS-1:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/rtlpm_ctrl.sv
// rtlpm_ctrl: sequencer for insert and lookup walks over the trie.
// Depends on rtlpm_pkg for the command and status structs.
`default_nettype none
module rtlpm_ctrl
  import rtlpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t st,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (st.is_lookup) begin
          cmd.track = 1'b1;
          if (st.at_end || st.link_null) begin
            cmd.finish = 1'b1;
            state_next = ST_RESP;
          end else begin
            cmd.descend = 1'b1;
          end
        end else if (st.at_end) begin
          cmd.mark   = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_RESP;
        end else if (!st.link_null) begin
          cmd.descend = 1'b1;
        end else if (st.store_full) begin
          cmd.fail   = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_RESP;
        end else begin
          cmd.alloc = 1'b1;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

endmodule
`default_nettype wire

>>> rtl/rtlpm_dp.sv
// rtlpm_dp: node store, bump allocator, walk registers and result registers.
// Depends on rtlpm_pkg; driven by rtlpm_ctrl through dp_cmd_t.
`default_nettype none
module rtlpm_dp
  import rtlpm_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int PORT_BITS  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             st,
  input  logic                 kind,
  input  logic [31:0]          addr,
  input  logic [31:0]          mask,
  input  logic [31:0]          hop_addr,
  input  logic [PORT_BITS-1:0] out_port,
  input  logic                 local_flag,
  output logic [31:0]          res_hop,
  output logic [PORT_BITS-1:0] res_port,
  output logic                 res_local,
  output logic                 unreachable,
  output logic                 status
);

  localparam int AW   = $clog2(NODE_COUNT);
  localparam int NF_W = $clog2(NODE_COUNT + 1);

  // node store; entry 0 lives in root registers
  logic [AW-1:0]        mem_c0  [NODE_COUNT];
  logic [AW-1:0]        mem_c1  [NODE_COUNT];
  logic                 mem_mk  [NODE_COUNT];
  logic [31:0]          mem_hop [NODE_COUNT];
  logic [PORT_BITS-1:0] mem_port[NODE_COUNT];
  logic                 mem_loc [NODE_COUNT];

  logic [AW-1:0]        rd_c0, rd_c1;
  logic                 rd_mk;
  logic [31:0]          rd_hop;
  logic [PORT_BITS-1:0] rd_port;
  logic                 rd_loc;

  logic [AW-1:0]        root_c0, root_c1;
  logic                 root_mk;
  logic [31:0]          root_hop;
  logic [PORT_BITS-1:0] root_port;
  logic                 root_loc;

  // held word for root or a fresh node
  logic [AW-1:0]        w_c0, w_c1;
  logic                 w_mk;
  logic [31:0]          w_hop;
  logic [PORT_BITS-1:0] w_port;
  logic                 w_loc;
  logic                 from_mem;

  logic                 kind_r;
  logic [31:0]          addr_r, path_bits, mask_bits, hop_r;
  logic [PORT_BITS-1:0] port_r;
  logic                 loc_r;
  logic [DEPTH_W-1:0]   depth;
  logic [AW-1:0]        node;
  logic [NF_W-1:0]      next_free;

  logic                 found;
  logic [31:0]          best_hop;
  logic [PORT_BITS-1:0] best_port;
  logic                 best_loc;

  logic [AW-1:0]        cur_c0, cur_c1, link, fresh;
  logic                 cur_mk, cur_loc, bit_now;
  logic [31:0]          cur_hop;
  logic [PORT_BITS-1:0] cur_port;

  logic                 wr_en;
  logic [AW-1:0]        wd_c0, wd_c1;
  logic                 wd_mk, wd_loc;
  logic [31:0]          wd_hop;
  logic [PORT_BITS-1:0] wd_port;

  logic                 hit;
  logic [31:0]          pick_hop;
  logic [PORT_BITS-1:0] pick_port;
  logic                 pick_loc;

  assign cur_c0   = from_mem ? rd_c0   : w_c0;
  assign cur_c1   = from_mem ? rd_c1   : w_c1;
  assign cur_mk   = from_mem ? rd_mk   : w_mk;
  assign cur_hop  = from_mem ? rd_hop  : w_hop;
  assign cur_port = from_mem ? rd_port : w_port;
  assign cur_loc  = from_mem ? rd_loc  : w_loc;

  assign bit_now = path_bits[TOP_BIT];
  assign link    = bit_now ? cur_c1 : cur_c0;
  assign fresh   = next_free[AW-1:0];

  assign st.is_lookup  = (kind_r == KIND_LOOKUP);
  assign st.at_end     = (depth == DEPTH_FULL) ||
                         ((kind_r == KIND_INSERT) && !mask_bits[TOP_BIT]);
  assign st.link_null  = (link == '0);
  assign st.store_full = (next_free == NF_W'(NODE_COUNT));

  // write word for the current node
  always_comb begin
    wd_c0   = cur_c0;
    wd_c1   = cur_c1;
    wd_mk   = cur_mk;
    wd_hop  = cur_hop;
    wd_port = cur_port;
    wd_loc  = cur_loc;
    if (cmd.alloc) begin
      if (bit_now) begin
        wd_c1 = fresh;
      end else begin
        wd_c0 = fresh;
      end
    end
    if (cmd.mark) begin
      wd_mk   = 1'b1;
      wd_hop  = swap_bytes(hop_r);
      wd_port = port_r;
      wd_loc  = loc_r;
    end
  end

  // a fresh node where the store ran out is written back cleared
  assign wr_en = cmd.alloc || cmd.mark || cmd.fail;

  always_ff @(posedge clk) begin
    if (wr_en && (node != '0)) begin
      mem_c0[node]   <= wd_c0;
      mem_c1[node]   <= wd_c1;
      mem_mk[node]   <= wd_mk;
      mem_hop[node]  <= wd_hop;
      mem_port[node] <= wd_port;
      mem_loc[node]  <= wd_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.descend) begin
      rd_c0   <= mem_c0[link];
      rd_c1   <= mem_c1[link];
      rd_mk   <= mem_mk[link];
      rd_hop  <= mem_hop[link];
      rd_port <= mem_port[link];
      rd_loc  <= mem_loc[link];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_c0 <= '0;
      root_c1 <= '0;
      root_mk <= 1'b0;
    end else if (wr_en && (node == '0)) begin
      root_c0 <= wd_c0;
      root_c1 <= wd_c1;
      root_mk <= wd_mk;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (node == '0)) begin
      root_hop  <= wd_hop;
      root_port <= wd_port;
      root_loc  <= wd_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= NF_W'(1);
    end else if (cmd.alloc) begin
      next_free <= next_free + NF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      from_mem <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.load) begin
      from_mem <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cmd.descend) begin
        from_mem <= 1'b1;
      end else if (cmd.alloc) begin
        from_mem <= 1'b0;
      end
      if (cmd.track && cur_mk) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= kind;
      addr_r    <= addr;
      path_bits <= addr;
      mask_bits <= mask;
      hop_r     <= hop_addr;
      port_r    <= out_port;
      loc_r     <= local_flag;
      depth     <= '0;
      node      <= '0;
      w_c0      <= root_c0;
      w_c1      <= root_c1;
      w_mk      <= root_mk;
      w_hop     <= root_hop;
      w_port    <= root_port;
      w_loc     <= root_loc;
    end else if (cmd.descend || cmd.alloc) begin
      path_bits <= {path_bits[30:0], 1'b0};
      mask_bits <= {mask_bits[30:0], 1'b0};
      depth     <= depth + DEPTH_W'(1);
      if (cmd.descend) begin
        node <= link;
      end else begin
        node   <= fresh;
        w_c0   <= '0;
        w_c1   <= '0;
        w_mk   <= 1'b0;
        w_hop  <= '0;
        w_port <= '0;
        w_loc  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.track && cur_mk) begin
      best_hop  <= cur_hop;
      best_port <= cur_port;
      best_loc  <= cur_loc;
    end
  end

  assign hit       = found || cur_mk;
  assign pick_hop  = cur_mk ? cur_hop  : best_hop;
  assign pick_port = cur_mk ? cur_port : best_port;
  assign pick_loc  = cur_mk ? cur_loc  : best_loc;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_hop     <= '0;
      res_port    <= '0;
      res_local   <= 1'b0;
      unreachable <= 1'b0;
      status      <= 1'b0;
      if (kind_r == KIND_INSERT) begin
        status <= cmd.fail;
      end else if (!hit) begin
        unreachable <= 1'b1;
      end else begin
        res_hop   <= pick_loc ? swap_bytes(addr_r) : pick_hop;
        res_port  <= pick_port;
        res_local <= pick_loc;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/route_trie_lpm_core.sv
// route_trie_lpm_core: top level of the IPv4 longest-prefix-match trie.
// Depends on rtlpm_pkg, rtlpm_ctrl and rtlpm_dp.
//
// Raise start for one cycle while busy is low to hand in a beat: kind 0
// inserts addr/mask with hop_addr, out_port and local_flag, kind 1 looks up
// addr. busy stays high until the result, which is shown for exactly one
// cycle with done high; the receiver cannot stall it. A beat walks the trie
// level by level, each descent being one read of the node memory, and busy
// is low again in the cycle after done.
// After reset the table is empty and no clearing pass is needed.
`default_nettype none
module route_trie_lpm_core
  import rtlpm_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int PORT_BITS  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [31:0]          addr,
  input  logic [31:0]          mask,
  input  logic [31:0]          hop_addr,
  input  logic [PORT_BITS-1:0] out_port,
  input  logic                 local_flag,
  output logic                 done,
  output logic [31:0]          res_hop,
  output logic [PORT_BITS-1:0] res_port,
  output logic                 res_local,
  output logic                 unreachable,
  output logic                 status
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  rtlpm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rtlpm_dp #(
    .NODE_COUNT (NODE_COUNT),
    .PORT_BITS  (PORT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .kind        (kind),
    .addr        (addr),
    .mask        (mask),
    .hop_addr    (hop_addr),
    .out_port    (out_port),
    .local_flag  (local_flag),
    .res_hop     (res_hop),
    .res_port    (res_port),
    .res_local   (res_local),
    .unreachable (unreachable),
    .status      (status)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!unreachable && !res_local && (res_hop == '0)))
    else $error("store-full result carries lookup fields");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.descend || cmd.alloc) |-> !st.at_end)
    else $error("walk stepped past its end");
`endif

endmodule
`default_nettype wire

>>> sim/route_trie_lpm_checker.sv
// route_trie_lpm_checker: watches the command and result ports of the trie LPM core,
// keeps its own copy of the route trie and compares every result beat in order.
// Depends on rtlpm_pkg for the kind codes.
module route_trie_lpm_checker
  import rtlpm_pkg::*;
#(
  parameter int NODES = 4096,
  parameter int PW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  logic          kind,
  input  logic [31:0]   addr,
  input  logic [31:0]   mask,
  input  logic [31:0]   hop_addr,
  input  logic [PW-1:0] out_port,
  input  logic          local_flag,
  input  logic          done,
  input  logic [31:0]   res_hop,
  input  logic [PW-1:0] res_port,
  input  logic          res_local,
  input  logic          unreachable,
  input  logic          status,
  output int            mismatches,
  output int            outstanding
);

  localparam int LW = $clog2(NODES);

  typedef struct packed {
    logic [31:0]   hop;
    logic [PW-1:0] port;
    logic          is_local;
    logic          miss;
    logic          full;
  } route_result_t;

  logic [LW-1:0] zero_link [NODES];
  logic [LW-1:0] one_link [NODES];
  logic          node_marked [NODES];
  logic [31:0]   node_hop [NODES];
  logic [PW-1:0] node_port [NODES];
  logic          node_local [NODES];
  int            next_node;

  route_result_t expected_q [$];

  initial mismatches = 0;

  function automatic logic [31:0] reorder_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  task automatic route_beat(input logic k, input logic [31:0] a, input logic [31:0] m,
                            input logic [31:0] h, input logic [PW-1:0] p, input logic lf);
    route_result_t r;
    int plen;
    int node;
    int nxt;
    int lvl;
    bit stuck;
    bit walking;
    r = '0;
    if (k == KIND_INSERT) begin
      plen = 0;
      while (plen < 32 && m[31-plen]) plen++;
      node = 0;
      stuck = 1'b0;
      for (lvl = 0; lvl < plen && !stuck; lvl++) begin
        nxt = a[31-lvl] ? one_link[node] : zero_link[node];
        if (nxt == 0) begin
          if (next_node >= NODES) begin
            stuck = 1'b1;
          end else begin
            nxt = next_node;
            next_node++;
            zero_link[nxt] = '0;
            one_link[nxt] = '0;
            node_marked[nxt] = 1'b0;
            if (a[31-lvl]) one_link[node] = nxt[LW-1:0];
            else zero_link[node] = nxt[LW-1:0];
          end
        end
        if (!stuck) node = nxt;
      end
      if (stuck) begin
        r.full = 1'b1;
      end else begin
        node_hop[node] = reorder_bytes(h);
        node_port[node] = p;
        node_local[node] = lf;
        node_marked[node] = 1'b1;
      end
    end else begin
      node = 0;
      lvl = 31;
      walking = 1'b1;
      r.miss = 1'b1;
      while (walking) begin
        if (node_marked[node]) begin
          r.miss = 1'b0;
          r.hop = node_hop[node];
          r.port = node_port[node];
          r.is_local = node_local[node];
        end
        if (lvl < 0) begin
          walking = 1'b0;
        end else begin
          nxt = a[lvl] ? one_link[node] : zero_link[node];
          if (nxt == 0) begin
            walking = 1'b0;
          end else begin
            node = nxt;
            lvl--;
          end
        end
      end
      if (!r.miss && r.is_local) r.hop = reorder_bytes(a);
    end
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      zero_link[0] = '0;
      one_link[0] = '0;
      node_marked[0] = 1'b0;
      next_node = 1;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual hop %0h port %0h",
                   $time, res_hop, res_port);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("res_hop", want.hop, res_hop);
          compare_field("res_port", want.port, res_port);
          compare_field("res_local", want.is_local, res_local);
          compare_field("unreachable", want.miss, unreachable);
          compare_field("status", want.full, status);
        end
      end
      if (start && !busy) route_beat(kind, addr, mask, hop_addr, out_port, local_flag);
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> sim/tb_route_trie_lpm_core.sv
// tb_route_trie_lpm_core: stimulus and verdict for the route trie LPM core.
// Depends on rtlpm_pkg, route_trie_lpm_core and route_trie_lpm_checker.
module tb_route_trie_lpm_core;
  import rtlpm_pkg::*;

  localparam int POOL = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        kind = KIND_INSERT;
  logic [31:0] addr = '0;
  logic [31:0] mask = '0;
  logic [31:0] hop_addr = '0;
  logic [5:0]  out_port = '0;
  logic        local_flag = 1'b0;
  logic        busy;
  logic        done;
  logic [31:0] res_hop;
  logic [5:0]  res_port;
  logic        res_local;
  logic        unreachable;
  logic        status;
  int          mismatches;
  int          outstanding;

  bit          idle_on = 1'b1;
  logic [31:0] base_pool [POOL];
  logic [31:0] recent_host = '0;

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  route_trie_lpm_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .addr(addr),
    .mask(mask), .hop_addr(hop_addr), .out_port(out_port), .local_flag(local_flag),
    .done(done), .res_hop(res_hop), .res_port(res_port), .res_local(res_local),
    .unreachable(unreachable), .status(status)
  );

  route_trie_lpm_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .addr(addr),
    .mask(mask), .hop_addr(hop_addr), .out_port(out_port), .local_flag(local_flag),
    .done(done), .res_hop(res_hop), .res_port(res_port), .res_local(res_local),
    .unreachable(unreachable), .status(status), .mismatches(mismatches),
    .outstanding(outstanding)
  );

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // start stays high across back-to-back beats; it only drops for an idle gap
  task automatic send_beat(input logic k, input logic [31:0] a, input logic [31:0] m,
                           input logic [31:0] h, input logic [5:0] p, input logic lf);
    if (idle_on && $urandom_range(99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 26) @(posedge clk);
      if ($urandom_range(19) == 0) repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    addr <= a;
    mask <= m;
    hop_addr <= h;
    out_port <= p;
    local_flag <= lf;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic pool_insert();
    logic [31:0] a;
    logic [31:0] m;
    int plen;
    plen = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 28);
    m = prefix_mask(plen);
    a = base_pool[$urandom_range(POOL - 1)];
    if ($urandom_range(3) == 0) a = a ^ ($urandom & 32'hFF);
    a = a ^ ($urandom & ~m);
    if (plen < 32 && $urandom_range(7) == 0) m = m | ($urandom & ((32'h1 << (31 - plen)) - 1));
    send_beat(KIND_INSERT, a, m, $urandom, $urandom_range(63), $urandom_range(3) == 0);
  endtask

  task automatic pool_lookup();
    logic [31:0] a;
    a = base_pool[$urandom_range(POOL - 1)] ^ ($urandom >> $urandom_range(8, 32));
    send_beat(KIND_LOOKUP, a, $urandom, $urandom, $urandom_range(63), $urandom_range(1));
  endtask

  initial begin
    int n;
    int r;
    logic [31:0] a;
    foreach (base_pool[i]) base_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, then nested prefixes, /32 leaves, link-local, odd masks, overwrite
    send_beat(KIND_LOOKUP, 32'h0000_0000, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, '1, '1, '1, 1'b1);
    send_beat(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 6'd1, 1'b0);
    send_beat(KIND_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 6'd2, 1'b0);
    send_beat(KIND_INSERT, 32'h0A01_0200, 32'hFFFF_FF00, 32'h1234_5678, 6'd63, 1'b1);
    send_beat(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_beat(KIND_INSERT, 32'h0A01_0203, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 6'd7, 1'b1);
    send_beat(KIND_LOOKUP, 32'h0A01_0203, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h0A01_0204, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h0A01_FF00, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h0AFF_FFFF, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h0B00_0000, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'hFFFF_FFFE, '0, '0, '0, 1'b0);
    send_beat(KIND_INSERT, 32'hC0A8_0000, 32'hFFFF_00FF, 32'hC0A8_0001, 6'd0, 1'b0);
    send_beat(KIND_LOOKUP, 32'hC0A8_ABCD, '0, '0, '0, 1'b0);
    send_beat(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0102_0304, 6'd5, 1'b0);
    send_beat(KIND_LOOKUP, 32'h0A20_0000, '0, '0, '0, 1'b0);
    send_beat(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h0, 6'd0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h8000_0001, '0, '0, '0, 1'b0);
    send_beat(KIND_LOOKUP, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);

    // no default route yet, so misses stay possible
    for (n = 0; n < 1000; n++) begin
      idle_on = !(n >= 400 && n < 600);
      r = $urandom_range(99);
      if (r < 40) pool_insert();
      else if (r < 85) pool_lookup();
      else if (r < 95)
        send_beat(KIND_LOOKUP, $urandom, $urandom, $urandom, $urandom_range(63),
                  $urandom_range(1));
      else
        send_beat(KIND_INSERT, $urandom, $urandom | 32'h8000_0000, $urandom,
                  $urandom_range(63), $urandom_range(1));
    end
    wait_drain();

    // default route, then fill the node store with host routes
    send_beat(KIND_INSERT, $urandom, 32'h0, $urandom, $urandom_range(63), 1'b0);
    send_beat(KIND_LOOKUP, $urandom, '0, '0, '0, 1'b0);
    for (n = 0; n < 330; n++) begin
      r = $urandom_range(99);
      if (r < 65) begin
        a = $urandom;
        recent_host = a;
        send_beat(KIND_INSERT, a,
                  ($urandom_range(4) == 0) ? prefix_mask($urandom_range(16, 31)) : '1,
                  $urandom, $urandom_range(63), $urandom_range(3) == 0);
      end else if (r < 80) begin
        pool_insert();
      end else if (r < 90) begin
        send_beat(KIND_LOOKUP, recent_host, '0, '0, '0, 1'b0);
      end else begin
        pool_lookup();
      end
    end
    wait_drain();
    repeat (40) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rtlpm_pkg.sv
rtl/rtlpm_ctrl.sv
rtl/rtlpm_dp.sv
rtl/route_trie_lpm_core.sv
sim/route_trie_lpm_checker.sv
sim/tb_route_trie_lpm_core.sv
